// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, suspended while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check on the rising clock edge that also runs during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/kfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver package
// Shared types, codes and reset values of the KISS frame receiver.
// ----------------------------------------------------------------------------
package kfr_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int POS_WIDTH       = 6;
   localparam int POS_MAX         = 63;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 24;

   // Input operations.
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result kinds.
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_END      = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ESCAPE         = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ESCAPED_END    = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ESCAPED_ESCAPE = 8'd3;

   // Register reset values.
   localparam logic [BYTE_WIDTH-1:0] RESET_FRAME_END      = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] RESET_ESCAPE         = 8'hDB;
   localparam logic [BYTE_WIDTH-1:0] RESET_ESCAPED_END    = 8'hDC;
   localparam logic [BYTE_WIDTH-1:0] RESET_ESCAPED_ESCAPE = 8'hDD;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] frame_end_code;
      logic [BYTE_WIDTH-1:0] escape_code;
      logic [BYTE_WIDTH-1:0] escaped_end_code;
      logic [BYTE_WIDTH-1:0] escaped_escape_code;
   } cfg_type;

   typedef struct packed {
      logic                 kind;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic [POS_WIDTH-1:0]  position;
      logic [POS_WIDTH-1:0]  frame_length;
   } result_type;

endpackage

// File: hw/rtl/kfr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver configuration registers
// Holds the four framing codes and takes writes from the register channel.
// ----------------------------------------------------------------------------
module kfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kfr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kfr_pkg::BYTE_WIDTH-1:0]       csr_data,
   output kfr_pkg::cfg_type                     cfg
);
   import kfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_END:      cfg_in.frame_end_code      = csr_data;
            REG_ESCAPE:         cfg_in.escape_code         = csr_data;
            REG_ESCAPED_END:    cfg_in.escaped_end_code    = csr_data;
            REG_ESCAPED_ESCAPE: cfg_in.escaped_escape_code = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_end_code      <= RESET_FRAME_END;
         cfg_ff.escape_code         <= RESET_ESCAPE;
         cfg_ff.escaped_end_code    <= RESET_ESCAPED_END;
         cfg_ff.escaped_escape_code <= RESET_ESCAPED_ESCAPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/kfr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver decode core
// Input register, framing state and the single-pass byte decoder.
// ----------------------------------------------------------------------------
module kfr_core #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kfr_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [kfr_pkg::BYTE_WIDTH-1:0]    req_byte,
   output logic                              res_valid,
   input  logic                              res_ready,
   output kfr_pkg::result_type               res
);
   import kfr_pkg::*;

   // The write position saturates at the last buffer slot, and never above
   // what the position field can hold.
   localparam logic [POS_WIDTH-1:0] POS_CAP =
      POS_WIDTH'((BUFFER_DEPTH - 1 > POS_MAX) ? POS_MAX : BUFFER_DEPTH - 1);

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   logic                  escape_ff, escape_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  held_ff, held_in;

   logic                  has_result;
   logic                  advance;
   logic [POS_WIDTH-1:0]  pos_next;
   result_type            result;

   assign pos_next = (pos_ff == POS_CAP) ? POS_CAP : pos_ff + POS_WIDTH'(1);

   always_comb begin
      has_result = 1'b0;
      result     = '0;
      escape_in  = escape_ff;
      pos_in     = pos_ff;
      held_in    = held_ff;
      if (in_op_ff == OP_RELEASE) begin
         pos_in  = '0;
         held_in = 1'b0;
      end else if (!held_ff) begin
         if (!escape_ff) begin
            priority if (in_byte_ff == cfg.frame_end_code) begin
               // An empty frame is skipped without a result.
               if (pos_ff != '0) begin
                  has_result          = 1'b1;
                  result.kind         = KIND_FRAME;
                  result.frame_length = pos_ff;
                  held_in             = 1'b1;
               end
            end else if (in_byte_ff == cfg.escape_code) begin
               escape_in = 1'b1;
            end else begin
               has_result       = 1'b1;
               result.kind      = KIND_DATA;
               result.data_byte = in_byte_ff;
               result.position  = pos_ff;
               pos_in           = pos_next;
            end
         end else begin
            escape_in = 1'b0;
            priority if (in_byte_ff == cfg.escaped_end_code) begin
               has_result       = 1'b1;
               result.kind      = KIND_DATA;
               result.data_byte = cfg.frame_end_code;
               result.position  = pos_ff;
               pos_in           = pos_next;
            end else if (in_byte_ff == cfg.escaped_escape_code) begin
               has_result       = 1'b1;
               result.kind      = KIND_DATA;
               result.data_byte = cfg.escape_code;
               result.position  = pos_ff;
               pos_in           = pos_next;
            end else begin
               has_result = 1'b0;
            end
         end
      end
   end

   // An item that gives no result never waits on the output register.
   assign advance   = in_valid_ff && (!has_result || res_ready);
   assign req_ready = !in_valid_ff || advance;
   assign res_valid = in_valid_ff && has_result;
   assign res       = result;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
         pos_ff    <= '0;
         held_ff   <= 1'b0;
      end else if (advance) begin
         escape_ff <= escape_in;
         pos_ff    <= pos_in;
         held_ff   <= held_in;
      end
   end

endmodule

// File: hw/rtl/kfr_rsp_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver result register
// Holds one result transaction and packs it onto the result stream.
// ----------------------------------------------------------------------------
module kfr_rsp_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                res_valid,
   output logic                                res_ready,
   input  kfr_pkg::result_type                 res,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kfr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic [0:0]                          rsp_tuser
);
   import kfr_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   assign res_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {4'b0000, res_ff.frame_length, res_ff.position, res_ff.data_byte};

endmodule

// File: hw/rtl/kiss_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver
// Strips KISS framing from received serial bytes and reports data and frames.
// ----------------------------------------------------------------------------
// Usage:
//   The req stream carries one transaction per received byte (tuser 0) or a
//   release (tuser 1) that clears the write position and ends the hold.
//   The rsp stream carries at most one transaction per request: a decoded
//   byte with its buffer slot (tuser 0) or a frame-complete event with its
//   length (tuser 1). Escape and empty-frame bytes give no transaction.
//   The csr channel writes the four framing codes and is always ready. The user
//   writes it only while the block is idle; the block does not enforce this.
//   A request is registered in the input register at its accept edge, and its
//   result is loaded into the output register once that register can take it,
//   which raises rsp_tvalid. One request is taken every cycle while the rsp
//   side does not stall; a request that gives no result never waits on the
//   output register.
//   When the rsp side stalls, the output register holds its transaction and
//   the input register keeps accepting until a second result backs up.
//   Reset empties both registers, restores the default codes and clears the
//   escape flag, the write position and the hold flag.
// ----------------------------------------------------------------------------
module kiss_frame_receiver #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: rx_byte[7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kfr_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // req_tuser: operation[0]
   input  logic [0:0]                          req_tuser,
   // rsp_tdata: data_byte[7:0], position[13:8], frame_length[19:14], zero[23:20]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kfr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // rsp_tuser: kind[0]
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kfr_pkg::BYTE_WIDTH-1:0]      csr_data
);
   import kfr_pkg::*;

   cfg_type    cfg;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   kfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kfr_core #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[0]),
      .req_byte  (req_tdata[BYTE_WIDTH-1:0]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   kfr_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/kfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame receiver checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kfr_checker #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [kfr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic [0:0]                          rsp_tuser
);
   import kfr_pkg::*;

   localparam logic [POS_WIDTH-1:0] POS_CAP =
      POS_WIDTH'((BUFFER_DEPTH - 1 > POS_MAX) ? POS_MAX : BUFFER_DEPTH - 1);

   logic                      rsp_stall;
   logic                      is_frame;
   logic                      is_data;
   logic [RSP_DATA_WIDTH:0]   rsp_word;
   logic [13:0]               rsp_lo;
   logic [POS_WIDTH-1:0]      rsp_slot;
   logic [POS_WIDTH-1:0]      rsp_length;
   logic [3:0]                rsp_pad;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign is_frame   = rsp_tvalid && rsp_tuser[0] == KIND_FRAME;
   assign is_data    = rsp_tvalid && rsp_tuser[0] == KIND_DATA;
   assign rsp_word   = {rsp_tuser, rsp_tdata};
   assign rsp_lo     = rsp_tdata[13:0];
   assign rsp_slot   = rsp_tdata[13:8];
   assign rsp_length = rsp_tdata[19:14];
   assign rsp_pad    = rsp_tdata[23:20];

   // A stalled result transaction must hold.
   `ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_word), "stalled result changed")

   // A frame event carries a nonzero length and no data or position.
   `ASSERT_CLK(a_frame_fields, is_frame |-> rsp_length != '0 && rsp_lo == '0, "bad frame event")

   // A data byte carries no length and a slot within the saturated range.
   `ASSERT_CLK(a_data, is_data |-> rsp_length == '0 && rsp_slot <= POS_CAP, "bad data byte")

   // The unused top bits of the result stay zero.
   `ASSERT_CLK(a_padding, rsp_tvalid |-> rsp_pad == '0, "nonzero padding")

   // Reset empties the output register.
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind kiss_frame_receiver kfr_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_checker (.*);
